### rtl/mm_pkg.sv
// ============================================================================
// mm_pkg
// Shared constants for the fixed-point matrix multiplier: command codes,
// register indexes and field widths.
// ============================================================================
package mm_pkg;

    // Input word commands
    localparam logic [1:0] CMD_WR_A    = 2'd0;
    localparam logic [1:0] CMD_WR_B    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 32;
    localparam int PROD_W = 64;
    localparam int DIM_W  = 4;

    // Packed word widths (padded to whole bytes)
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    // Default store dimension
    localparam int MAX_DIM_DEF = 8;

endpackage

### rtl/matrix_multiply.sv
// ============================================================================
// matrix_multiply
// Fixed-point dense matrix multiplier C = A * B, signed Q16.16 elements,
// saturating Q32.32 accumulation, A and B held in on-chip memories.
// ============================================================================
// Element writes (commands 0 and 1) are taken one word per cycle. A compute
// word (command 2) holds off the input channel while the block walks C in
// row-major order: each C element streams inner_dim A/B word pairs out of the
// two memories, one pair per cycle, through one 32x32 multiplier and a
// saturating 64-bit accumulator; a stall on the result channel holds the walk.
// Dimension registers of 0 count as 1 and values above MAX_DIM count as
// MAX_DIM. Writes outside the store are dropped; command 3 is ignored.
// ============================================================================
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,

    // Input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // command[1:0], row[4:2], col[7:5], value[39:8]

    // Result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // out_row[2:0], out_col[5:3], product_value[69:6]
    output logic                 m_tlast
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic signed [PROD_W-1:0] SAT_MAX = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN = {1'b1, {(PROD_W-1){1'b0}}};

    // Input field split
    logic [CMD_W-1:0]        in_cmd;
    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_val;

    assign in_cmd = s_tdata[1:0];
    assign in_row = s_tdata[4:2];
    assign in_col = s_tdata[7:5];
    assign in_val = s_tdata[39:8];

    // Configuration registers
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= DIM_W'(8);
            inner_dim_reg <= DIM_W'(8);
            cols_b_reg    <= DIM_W'(8);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp a dimension register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (v > MAX_DIM_C)
            return MAX_DIM_C;
        else
            return v;
    endfunction

    // Control state
    logic [1:0]       state_reg;
    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic [DIM_W-1:0] nr_reg, nk_reg, nc_reg;

    logic in_acc, is_wr_a, is_wr_b, in_range;
    logic issue, last_j, last_k, last_i;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_range = ({1'b0, in_row} < MAX_DIM_C) && ({1'b0, in_col} < MAX_DIM_C);
    assign is_wr_a  = in_acc && (in_cmd == CMD_WR_A) && in_range;
    assign is_wr_b  = in_acc && (in_cmd == CMD_WR_B) && in_range;

    assign issue  = (state_reg == ST_ISSUE);
    assign last_j = ({1'b0, j_reg} == nk_reg - DIM_W'(1));
    assign last_k = ({1'b0, k_reg} == nc_reg - DIM_W'(1));
    assign last_i = ({1'b0, i_reg} == nr_reg - DIM_W'(1));

    // Memory addresses
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    assign wr_addr   = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
    assign rd_addr_a = ADDR_W'(int'(i_reg) * MAX_DIM + int'(j_reg));
    assign rd_addr_b = ADDR_W'(int'(j_reg) * MAX_DIM + int'(k_reg));

    // A and B stores, registered read
    logic signed [VAL_W-1:0] mem_a [DEPTH];
    logic signed [VAL_W-1:0] mem_b [DEPTH];
    logic signed [VAL_W-1:0] a_q, b_q;

    always_ff @(posedge aclk) begin
        if (is_wr_a)
            mem_a[wr_addr] <= in_val;
        if (issue)
            a_q <= mem_a[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (is_wr_b)
            mem_b[wr_addr] <= in_val;
        if (issue)
            b_q <= mem_b[rd_addr_b];
    end

    // Pipeline tags: read -> multiply -> accumulate
    logic rd_vld_reg, rd_first_reg, rd_last_reg;
    logic prod_vld_reg, prod_first_reg, prod_last_reg;
    logic done_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            done_reg     <= prod_vld_reg && prod_last_reg;
        end
        rd_first_reg   <= (j_reg == '0);
        rd_last_reg    <= last_j;
        prod_first_reg <= rd_first_reg;
        prod_last_reg  <= rd_last_reg;
    end

    // Multiply
    always_ff @(posedge aclk) begin
        if (rd_vld_reg)
            prod_reg <= PROD_W'(a_q) * PROD_W'(b_q);
    end

    // Saturating accumulate, restarts from zero on each C element
    logic signed [PROD_W-1:0] acc_base;
    logic signed [PROD_W:0]   acc_sum;
    logic signed [PROD_W-1:0] acc_next;

    always_comb begin
        acc_base = prod_first_reg ? '0 : acc_reg;
        acc_sum  = {acc_base[PROD_W-1], acc_base} + {prod_reg[PROD_W-1], prod_reg};
        if (acc_sum[PROD_W] != acc_sum[PROD_W-1])
            acc_next = acc_sum[PROD_W] ? SAT_MIN : SAT_MAX;
        else
            acc_next = acc_sum[PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_next;
    end

    // Output register
    logic                     m_tvalid_reg;
    logic                     m_tlast_reg;
    logic [IDX_W-1:0]         m_row_reg, m_col_reg;
    logic signed [PROD_W-1:0] m_val_reg;
    logic                     out_free, out_load;

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
        if (out_load) begin
            m_row_reg   <= i_reg;
            m_col_reg   <= k_reg;
            m_val_reg   <= acc_reg;
            m_tlast_reg <= last_i && last_k;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {2'b00, m_val_reg, m_col_reg, m_row_reg};

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            nr_reg    <= DIM_W'(1);
            nk_reg    <= DIM_W'(1);
            nc_reg    <= DIM_W'(1);
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc && (in_cmd == CMD_COMPUTE)) begin
                        nr_reg    <= clamp_dim(rows_a_reg);
                        nk_reg    <= clamp_dim(inner_dim_reg);
                        nc_reg    <= clamp_dim(cols_b_reg);
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (last_j)
                        state_reg <= ST_WAIT;
                    else
                        j_reg <= j_reg + IDX_W'(1);
                end
                ST_WAIT: begin
                    if (done_reg)
                        state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        j_reg <= '0;
                        if (last_k) begin
                            k_reg <= '0;
                            if (last_i) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                i_reg     <= i_reg + IDX_W'(1);
                                state_reg <= ST_ISSUE;
                            end
                        end else begin
                            k_reg     <= k_reg + IDX_W'(1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Checks
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !rd_vld_reg && !prod_vld_reg && !done_reg)
        else $error("multiply pipeline busy while accepting input");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> state_reg == ST_WAIT)
        else $error("element finished outside wait state");

    a_j_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> {1'b0, j_reg} < nk_reg)
        else $error("inner index beyond inner dimension");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg)
        else $error("result not presented after load");

endmodule

### sim/tb.sv
// ============================================================================
// tb
// Self-checking bench for the fixed-point matrix multiplier. A short table of
// directed words (1x1 products, Q16.16 extremes, saturation both ways, ignored
// words, clamped dimensions) is followed by random load/compute sequences with
// random input gaps and result back-pressure. Every result word is checked
// against the table's sums or an in-bench model of the stores and saturating sums.
// ============================================================================
module tb;
    import mm_pkg::*;

    localparam logic [1:0] CMD_NONE  = 2'd3;   // unused command, dropped by the block
    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped register index

    localparam int RANDOM_ITEMS = 370;
    localparam int DRAIN_CYCLES = 16;          // settle time after the last pending result
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_PRINTS   = 40;

    localparam logic signed [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

    // one input word, packed to match s_tdata (command in the low bits)
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        row;
        logic [CMD_W-1:0]        cmd;
    } in_word_t;

    typedef struct {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [PROD_W-1:0] sum;
        logic                     last;
    } c_elem_t;

    typedef struct {
        bit               is_cfg;
        logic [1:0]       reg_idx;
        logic [DIM_W-1:0] reg_val;
        in_word_t         w;
        bit               typed;
        logic [63:0]      typed_sum;
    } plan_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [DIM_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    matrix_multiply dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state: stores, dimension registers, pending C elements
    logic signed [VAL_W-1:0] a_mem [0:63];
    logic signed [VAL_W-1:0] b_mem [0:63];
    bit                      a_set [0:63];
    bit                      b_set [0:63];
    logic [DIM_W-1:0]        dim_rows;
    logic [DIM_W-1:0]        dim_inner;
    logic [DIM_W-1:0]        dim_cols;
    c_elem_t                 c_pending[$];

    int  n_errors = 0;
    int  stall_count = 0;
    bit  tx_burst = 0;
    bit  rx_burst = 0;
    bit  hold_req = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        if (n_errors < MAX_PRINTS)
            $display("mismatch: %s", msg);
        n_errors++;
    endtask

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 8)
            return 8;
        return int'(v);
    endfunction

    function automatic logic signed [63:0] sat_accum(input logic signed [63:0] acc,
                                                     input logic signed [63:0] term);
        logic [64:0] wide;
        wide = {acc[63], acc} + {term[63], term};
        if (wide[64] != wide[63])
            return wide[64] ? SUM_MIN : SUM_MAX;
        return wide[63:0];
    endfunction

    // apply one accepted word to the stores; a compute queues all of C
    task automatic track_matrices(input in_word_t w);
        int                nr;
        int                nk;
        int                nc;
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        c_elem_t           e;
        case (w.cmd)
            CMD_WR_A: a_mem[{w.row, w.col}] = w.value;
            CMD_WR_B: b_mem[{w.row, w.col}] = w.value;
            CMD_COMPUTE: begin
                nr = eff_dim(dim_rows);
                nk = eff_dim(dim_inner);
                nc = eff_dim(dim_cols);
                for (int i = 0; i < nr; i++) begin
                    for (int k = 0; k < nc; k++) begin
                        acc = '0;
                        for (int j = 0; j < nk; j++) begin
                            prod = a_mem[i*8+j] * b_mem[j*8+k];
                            acc  = sat_accum(acc, prod);
                        end
                        e.row  = i[IDX_W-1:0];
                        e.col  = k[IDX_W-1:0];
                        e.sum  = acc;
                        e.last = (i == nr - 1) && (k == nc - 1);
                        c_pending.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // offer one word; valid stays high across back-to-back words
    task automatic send_word(input in_word_t w, input bit typed, input logic [63:0] tsum);
        int      gap;
        c_elem_t e;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (typed) begin
            e.row  = '0;
            e.col  = '0;
            e.sum  = tsum;
            e.last = 1'b1;
            c_pending.push_back(e);
        end else begin
            track_matrices(w);
        end
    endtask

    // wait until every queued C element is out and the block has gone quiet
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (c_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ROWS_A:    dim_rows  = val;
            REG_INNER_DIM: dim_inner = val;
            REG_COLS_B:    dim_cols  = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg  = 1'b1;
        p.reg_idx = idx;
        p.reg_val = val;
        return p;
    endfunction

    function automatic plan_row_t word_row(input logic [1:0] cmd, input logic [2:0] r,
                                           input logic [2:0] c, input logic [31:0] v,
                                           input bit typed, input logic [63:0] tsum);
        plan_row_t p;
        p = '{default: '0};
        p.w.cmd     = cmd;
        p.w.row     = r;
        p.w.col     = c;
        p.w.value   = v;
        p.typed     = typed;
        p.typed_sum = tsum;
        return p;
    endfunction

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;   // near zero
            default: return $urandom;
        endcase
    endfunction

    // mostly small dimensions; now and then 0, MAX_DIM or beyond
    function automatic logic [DIM_W-1:0] draw_dim();
        case ($urandom_range(0, 11))
            7:       return 4'd0;
            8:       return 4'd8;
            9:       return DIM_W'($urandom_range(9, 15));
            10, 11:  return DIM_W'($urandom_range(4, 6));
            default: return DIM_W'($urandom_range(1, 3));
        endcase
    endfunction

    // directed table: 1x1 and 1xNx1 products whose values read off directly
    task automatic run_directed();
        plan_row_t plan[$];
        plan.push_back(cfg_row(REG_ROWS_A, 4'd0));
        plan.push_back(cfg_row(REG_INNER_DIM, 4'd1));
        plan.push_back(cfg_row(REG_COLS_B, 4'd0));
        plan.push_back(cfg_row(REG_SPARE, 4'd15));
        plan.push_back(word_row(CMD_WR_A, 0, 0, 32'h0001_0000, 0, 0));
        plan.push_back(word_row(CMD_WR_B, 0, 0, 32'h0002_0000, 0, 0));
        plan.push_back(word_row(CMD_COMPUTE, 0, 0, 0, 1, 64'h0000_0002_0000_0000));
        plan.push_back(word_row(CMD_WR_A, 0, 0, 32'h8000_0000, 0, 0));
        plan.push_back(word_row(CMD_WR_B, 0, 0, 32'h8000_0000, 0, 0));
        plan.push_back(word_row(CMD_COMPUTE, 0, 0, 0, 1, 64'h4000_0000_0000_0000));
        plan.push_back(word_row(CMD_WR_B, 0, 0, 32'h7FFF_FFFF, 0, 0));
        // stored outside the configured size, and a dropped command: no effect
        plan.push_back(word_row(CMD_WR_A, 7, 7, 32'hFFFF_FFFF, 0, 0));
        plan.push_back(word_row(CMD_NONE, 7, 7, 32'hFFFF_FFFF, 0, 0));
        plan.push_back(word_row(CMD_COMPUTE, 7, 7, 32'hFFFF_FFFF, 1, 64'hC000_0000_8000_0000));
        // two min*min terms overflow to the positive bound
        plan.push_back(cfg_row(REG_INNER_DIM, 4'd2));
        plan.push_back(word_row(CMD_WR_A, 0, 1, 32'h8000_0000, 0, 0));
        plan.push_back(word_row(CMD_WR_B, 0, 0, 32'h8000_0000, 0, 0));
        plan.push_back(word_row(CMD_WR_B, 1, 0, 32'h8000_0000, 0, 0));
        plan.push_back(word_row(CMD_COMPUTE, 0, 0, 0, 1, SUM_MAX));
        // three min*max terms overflow to the negative bound
        plan.push_back(cfg_row(REG_INNER_DIM, 4'd3));
        plan.push_back(word_row(CMD_WR_A, 0, 2, 32'h8000_0000, 0, 0));
        plan.push_back(word_row(CMD_WR_B, 0, 0, 32'h7FFF_FFFF, 0, 0));
        plan.push_back(word_row(CMD_WR_B, 1, 0, 32'h7FFF_FFFF, 0, 0));
        plan.push_back(word_row(CMD_WR_B, 2, 0, 32'h7FFF_FFFF, 0, 0));
        plan.push_back(word_row(CMD_COMPUTE, 0, 0, 0, 1, SUM_MIN));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_block();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                if (plan[i].w.cmd == CMD_WR_A)
                    a_set[{plan[i].w.row, plan[i].w.col}] = 1'b1;
                if (plan[i].w.cmd == CMD_WR_B)
                    b_set[{plan[i].w.row, plan[i].w.col}] = 1'b1;
                send_word(plan[i].w, plan[i].typed, plan[i].typed_sum);
            end
        end
    endtask

    // random sequences: optional resize, load of every needed entry, mostly a compute
    task automatic run_random();
        int       n_sent;
        int       nr;
        int       nk;
        int       nc;
        int       n_noise;
        int       pick;
        in_word_t w;
        in_word_t tmp;
        in_word_t batch[$];
        n_sent = 0;
        for (int seq = 0; n_sent < RANDOM_ITEMS; seq++) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if (seq <= 2 || (seq != 3 && $urandom_range(0, 2) == 0)) begin
                drain_block();
                if (seq == 1) begin
                    // full size, with out-of-range values clamped to MAX_DIM
                    write_reg(REG_ROWS_A, 4'd15);
                    write_reg(REG_INNER_DIM, 4'd8);
                    write_reg(REG_COLS_B, 4'd9);
                end else if (seq == 2) begin
                    write_reg(REG_ROWS_A, 4'd4);
                    write_reg(REG_INNER_DIM, 4'd3);
                    write_reg(REG_COLS_B, 4'd4);
                end else begin
                    if (seq == 0 || $urandom_range(0, 1))
                        write_reg(REG_ROWS_A, draw_dim());
                    if (seq == 0 || $urandom_range(0, 1))
                        write_reg(REG_INNER_DIM, draw_dim());
                    if (seq == 0 || $urandom_range(0, 1))
                        write_reg(REG_COLS_B, draw_dim());
                    if ($urandom_range(0, 7) == 0)
                        write_reg(REG_SPARE, DIM_W'($urandom_range(0, 15)));
                end
            end
            nr = eff_dim(dim_rows);
            nk = eff_dim(dim_inner);
            nc = eff_dim(dim_cols);

            // every entry the product reads gets written at least once
            batch.delete();
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nk; j++) begin
                    if (!a_set[i*8+j] || $urandom_range(0, 1)) begin
                        w.cmd = CMD_WR_A; w.row = i; w.col = j; w.value = draw_value();
                        batch.push_back(w);
                        a_set[i*8+j] = 1'b1;
                    end
                end
            end
            for (int j = 0; j < nk; j++) begin
                for (int k = 0; k < nc; k++) begin
                    if (!b_set[j*8+k] || $urandom_range(0, 1)) begin
                        w.cmd = CMD_WR_B; w.row = j; w.col = k; w.value = draw_value();
                        batch.push_back(w);
                        b_set[j*8+k] = 1'b1;
                    end
                end
            end

            // noise: stray writes anywhere and dropped commands
            n_noise = $urandom_range(0, 3);
            for (int n = 0; n < n_noise; n++) begin
                pick  = $urandom_range(0, 2);
                w.cmd = (pick == 0) ? CMD_WR_A : (pick == 1) ? CMD_WR_B : CMD_NONE;
                w.row = $urandom_range(0, 7);
                w.col = $urandom_range(0, 7);
                w.value = draw_value();
                if (w.cmd == CMD_WR_A) a_set[{w.row, w.col}] = 1'b1;
                if (w.cmd == CMD_WR_B) b_set[{w.row, w.col}] = 1'b1;
                batch.push_back(w);
            end

            for (int i = batch.size() - 1; i > 0; i--) begin
                pick     = $urandom_range(0, i);
                tmp      = batch[i];
                batch[i] = batch[pick];
                batch[pick] = tmp;
            end
            foreach (batch[i]) begin
                send_word(batch[i], 0, 0);
                if (batch[i].cmd != CMD_NONE)
                    n_sent++;
            end

            // one long receiver hold-off while the next loads queue up behind it
            if (seq == 2)
                hold_req = 1'b1;
            // a few sequences end without a compute
            if (seq <= 2 || $urandom_range(0, 7) != 0) begin
                w.cmd = CMD_COMPUTE;
                w.row = $urandom_range(0, 7);
                w.col = $urandom_range(0, 7);
                w.value = $urandom;
                send_word(w, 0, 0);
                n_sent++;
            end
        end
    endtask

    // stimulus
    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        dim_rows  = 4'd8;
        dim_inner = 4'd8;
        dim_cols  = 4'd8;
        for (int i = 0; i < 64; i++) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            a_set[i] = 1'b0;
            b_set[i] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        drain_block();
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random ready gaps, one long hold-off on request
    initial begin : rx_side
        int              gap;
        int              n_rx;
        c_elem_t         e;
        logic [2:0]      got_row;
        logic [2:0]      got_col;
        logic [63:0]     got_sum;
        n_rx = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (n_rx % 16 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 4);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got_row = m_tdata[2:0];
            got_col = m_tdata[5:3];
            got_sum = m_tdata[69:6];
            if (c_pending.size() == 0) begin
                flag_mismatch($sformatf("unexpected word C(%0d,%0d) = %h",
                                        got_row, got_col, got_sum));
            end else begin
                e = c_pending.pop_front();
                if (got_row !== e.row)
                    flag_mismatch($sformatf("out_row %0d, want %0d", got_row, e.row));
                if (got_col !== e.col)
                    flag_mismatch($sformatf("out_col %0d, want %0d", got_col, e.col));
                if (got_sum !== e.sum)
                    flag_mismatch($sformatf("C(%0d,%0d) = %h, want %h",
                                            e.row, e.col, got_sum, e.sum));
                if (m_tlast !== e.last)
                    flag_mismatch($sformatf("C(%0d,%0d) last %b, want %b",
                                            e.row, e.col, m_tlast, e.last));
            end
            n_rx++;
        end
    end

    // watchdog: cycles without any handshake or register write
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

### sim.f
rtl/mm_pkg.sv
rtl/matrix_multiply.sv
sim/tb.sv
